// ===== hdl/awvn_pkg.sv =====
// Shared types and constants of the vertex normal accumulator.
package awvn_pkg;

  // Fixed field widths at the block boundary
  localparam int unsigned IDX_IN_W   = 12;
  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned CFG_W      = 64;

  // Action codes on the input channel
  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_TRI      = 2'd1,
    ACT_READ     = 2'd2,
    ACT_READ_CLR = 2'd3
  } action_e;

  // Item class decided by the front end
  typedef enum logic [2:0] {
    CLS_SKIP     = 3'd0,
    CLS_LOAD     = 3'd1,
    CLS_TRI      = 3'd2,
    CLS_READ     = 3'd3,
    CLS_READ_OOB = 3'd4
  } cls_e;

  // One queued item
  typedef struct packed {
    cls_e                          cls;
    logic                          clr;
    logic [IDX_IN_W-1:0]           ia;
    logic [IDX_IN_W-1:0]           ib;
    logic [IDX_IN_W-1:0]           ic;
    logic signed [COORD_IN_W-1:0]  cx;
    logic signed [COORD_IN_W-1:0]  cy;
    logic signed [COORD_IN_W-1:0]  cz;
  } item_t;

  // Back end to front end control
  typedef struct packed {
    logic pop;
    logic busy;
  } ctl_t;

endpackage

// ===== hdl/area_weighted_vertex_normals_unit.sv =====
// Top level of the area-weighted vertex normal accumulator.
//
// Input channel (in_valid_i / in_stall_o): one item per action. Load writes a
// vertex position, triangle adds (v1-v0)x(v2-v0) to its three corners with
// saturation, read returns the Q1.15 unit normal, read-and-clear also zeroes
// the vertex's sums. Only reads produce a result item on the output channel
// (out_valid_o / out_stall_i); out-of-range reads report degenerate.
// Items enter a two-entry queue in the front end, so two items can be taken
// while the back end works. The back end runs one item at a time: a load is
// written as it leaves the queue; a triangle makes three position reads, the
// product and three accumulator read-modify-writes. A read runs the
// bit-per-cycle shift normalizer, the 32-step square root once and the
// 17-step divider once per component; degenerate reads skip these.
// After reset the accumulator store is zeroed by a pass over all VERTICES
// entries, with in_stall_o high; the threshold register resets to 1.
// A stalled result holds in the output register; the back end waits on its
// next read until the register is free, while the queue fills up.
// cfg_ready_o is always high; write the threshold only when the block is idle.
module area_weighted_vertex_normals_unit #(
  parameter int unsigned VERTICES   = 4096,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned SUM_BITS   = 48
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             action_i,
  input  logic [awvn_pkg::IDX_IN_W-1:0]          index_a_i,
  input  logic [awvn_pkg::IDX_IN_W-1:0]          index_b_i,
  input  logic [awvn_pkg::IDX_IN_W-1:0]          index_c_i,
  input  logic signed [awvn_pkg::COORD_IN_W-1:0] coord_x_i,
  input  logic signed [awvn_pkg::COORD_IN_W-1:0] coord_y_i,
  input  logic signed [awvn_pkg::COORD_IN_W-1:0] coord_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [awvn_pkg::NORM_W-1:0]     normal_x_o,
  output logic signed [awvn_pkg::NORM_W-1:0]     normal_y_o,
  output logic signed [awvn_pkg::NORM_W-1:0]     normal_z_o,
  output logic                                   degenerate_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [awvn_pkg::CFG_W-1:0]             cfg_data_i
);
  import awvn_pkg::*;

  logic [CFG_W-1:0] min_len_sq_q;
  item_t item;
  logic  item_valid;
  ctl_t  ctl;

  // Threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_sq_q <= 64'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_len_sq_q <= cfg_data_i;
    end
  end

  awvn_front #(.VERTICES(VERTICES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .index_a_i    (index_a_i),
    .index_b_i    (index_b_i),
    .index_c_i    (index_c_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .ctl_i        (ctl),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  awvn_back #(
    .VERTICES   (VERTICES),
    .COORD_BITS (COORD_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .ctl_o        (ctl),
    .min_len_sq_i (min_len_sq_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .normal_x_o   (normal_x_o),
    .normal_y_o   (normal_y_o),
    .normal_z_o   (normal_z_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ===== hdl/awvn_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module awvn_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/awvn_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
module awvn_front #(
  parameter int unsigned VERTICES = 4096
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [1:0]                               action_i,
  input  logic [awvn_pkg::IDX_IN_W-1:0]            index_a_i,
  input  logic [awvn_pkg::IDX_IN_W-1:0]            index_b_i,
  input  logic [awvn_pkg::IDX_IN_W-1:0]            index_c_i,
  input  logic signed [awvn_pkg::COORD_IN_W-1:0]   coord_x_i,
  input  logic signed [awvn_pkg::COORD_IN_W-1:0]   coord_y_i,
  input  logic signed [awvn_pkg::COORD_IN_W-1:0]   coord_z_i,
  input  awvn_pkg::ctl_t                           ctl_i,
  output awvn_pkg::item_t                          item_o,
  output logic                                     item_valid_o
);
  import awvn_pkg::*;

  localparam logic [20:0] VTX = 21'(VERTICES);

  logic    oob_a, oob_b, oob_c;
  item_t   new_item;
  logic    push, pop;
  item_t   ent_q [2];
  logic    wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  // Range checks and classification
  assign oob_a = 21'(index_a_i) >= VTX;
  assign oob_b = 21'(index_b_i) >= VTX;
  assign oob_c = 21'(index_c_i) >= VTX;

  always_comb begin
    new_item.ia  = index_a_i;
    new_item.ib  = index_b_i;
    new_item.ic  = index_c_i;
    new_item.cx  = coord_x_i;
    new_item.cy  = coord_y_i;
    new_item.cz  = coord_z_i;
    new_item.clr = 1'b0;
    case (action_i)
      ACT_LOAD: begin
        new_item.cls = oob_a ? CLS_SKIP : CLS_LOAD;
      end
      ACT_TRI: begin
        new_item.cls = (oob_a || oob_b || oob_c) ? CLS_SKIP : CLS_TRI;
      end
      ACT_READ: begin
        new_item.cls = oob_a ? CLS_READ_OOB : CLS_READ;
      end
      ACT_READ_CLR: begin
        new_item.cls = oob_a ? CLS_READ_OOB : CLS_READ;
        new_item.clr = 1'b1;
      end
      default: begin
        new_item.cls = CLS_SKIP;
      end
    endcase
  end

  // Two-entry queue
  assign in_stall_o   = (cnt_q == 2'd2) || ctl_i.busy;
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = ctl_i.pop;
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> cnt_q != 2'd2) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
`endif

endmodule

// ===== hdl/awvn_back.sv =====
// Back end: position and accumulator stores, triangle update and normalization.
module awvn_back #(
  parameter int unsigned VERTICES   = 4096,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned SUM_BITS   = 48
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  awvn_pkg::item_t                        item_i,
  input  logic                                   item_valid_i,
  output awvn_pkg::ctl_t                         ctl_o,
  input  logic [awvn_pkg::CFG_W-1:0]             min_len_sq_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [awvn_pkg::NORM_W-1:0]     normal_x_o,
  output logic signed [awvn_pkg::NORM_W-1:0]     normal_y_o,
  output logic signed [awvn_pkg::NORM_W-1:0]     normal_z_o,
  output logic                                   degenerate_o
);
  import awvn_pkg::*;

  localparam int unsigned IDX_W   = $clog2(VERTICES);
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  localparam int unsigned EXT_W   = ((SUM_BITS > CROSS_W) ? SUM_BITS : CROSS_W) + 1;
  localparam int unsigned POS_W   = 3 * COORD_BITS;
  localparam int unsigned ACC_W   = 3 * SUM_BITS;
  localparam logic signed [EXT_W-1:0] SUM_HI =
    {{(EXT_W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SUM_LO =
    {{(EXT_W-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

  typedef enum logic [18:0] {
    ST_CLEAR    = 19'h00001,
    ST_IDLE     = 19'h00002,
    ST_PRD_A    = 19'h00004,
    ST_PRD_B    = 19'h00008,
    ST_PRD_C    = 19'h00010,
    ST_PWAIT    = 19'h00020,
    ST_MUL      = 19'h00040,
    ST_CROSS    = 19'h00080,
    ST_ACC_RD   = 19'h00100,
    ST_ACC_WR   = 19'h00200,
    ST_RD_SUM   = 19'h00400,
    ST_RD_WAIT  = 19'h00800,
    ST_SQ       = 19'h01000,
    ST_NORM     = 19'h02000,
    ST_TSQ      = 19'h04000,
    ST_SQRT     = 19'h08000,
    ST_DIV_INIT = 19'h10000,
    ST_DIV      = 19'h20000,
    ST_OUT      = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic out_valid_q, out_valid_d;
  logic signed [NORM_W-1:0] out_q [3];
  logic out_degen_q;

  item_t cur_q;
  logic [1:0] cnt_q;
  logic [4:0] step_q;
  logic signed [COORD_BITS-1:0] pa_q [3];
  logic signed [COORD_BITS-1:0] pb_q [3];
  logic signed [COORD_BITS-1:0] pc_q [3];
  logic signed [PROD_W-1:0] prod_q [6];
  logic signed [CROSS_W-1:0] cross_q [3];
  logic neg_q [3];
  logic [SUM_BITS-1:0] mag_q [3];
  logic [SUM_BITS-1:0] t_q [3];
  logic [SUM_BITS-1:0] m_q;
  logic [65:0] acc_q, acc_d;
  logic [63:0] root_n_q, root_res_q, root_bit_q, root_try;
  logic [47:0] div_n_q, div_cand;
  logic [16:0] quo_q, quo_d;
  logic signed [NORM_W-1:0] res_q [3];
  logic signed [NORM_W-1:0] comp_val;
  logic [NORM_W-2:0] comp_clamp;
  logic res_degen_q;

  // Store ports
  logic             pos_we, acc_we;
  logic [IDX_W-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
  logic [POS_W-1:0] pos_wdata, pos_rdata;
  logic [ACC_W-1:0] acc_wdata, acc_rdata;

  logic [IDX_W-1:0] ia_w, ib_w, ic_w, corner_w;
  logic signed [COORD_BITS-1:0] pos_rd [3];
  logic signed [SUM_BITS-1:0] sum_rd [3];
  logic [SUM_BITS-1:0] rd_mag [3];
  logic signed [SUM_BITS-1:0] acc_new [3];
  logic signed [EXT_W-1:0] acc_ext [3];
  logic signed [DIFF_W-1:0] du [3];
  logic signed [DIFF_W-1:0] dw [3];
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic all_zero, short_mag, degen, can_load;
  logic [SUM_BITS-1:0] m_max;

  awvn_ram #(.WIDTH(POS_W), .DEPTH(VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  awvn_ram #(.WIDTH(ACC_W), .DEPTH(VERTICES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  assign ia_w = IDX_W'(cur_q.ia);
  assign ib_w = IDX_W'(cur_q.ib);
  assign ic_w = IDX_W'(cur_q.ic);
  assign corner_w = (cnt_q == 2'd0) ? ia_w : ((cnt_q == 2'd1) ? ib_w : ic_w);

  // Unpack store words, magnitudes, saturating accumulate and edge differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_rd[k]  = pos_rdata[k*COORD_BITS +: COORD_BITS];
      sum_rd[k]  = acc_rdata[k*SUM_BITS +: SUM_BITS];
      rd_mag[k]  = sum_rd[k][SUM_BITS-1] ? (~sum_rd[k] + 1'b1) : sum_rd[k];
      acc_ext[k] = EXT_W'(sum_rd[k]) + EXT_W'(cross_q[k]);
      if (acc_ext[k] > SUM_HI) begin
        acc_new[k] = SUM_BITS'(SUM_HI);
      end else if (acc_ext[k] < SUM_LO) begin
        acc_new[k] = SUM_BITS'(SUM_LO);
      end else begin
        acc_new[k] = SUM_BITS'(acc_ext[k]);
      end
      du[k] = DIFF_W'(pb_q[k]) - DIFF_W'(pa_q[k]);
      dw[k] = DIFF_W'(pc_q[k]) - DIFF_W'(pa_q[k]);
    end
  end

  // Shared 32x32 squaring unit
  assign mul_a = (state_q == ST_SQ) ? mag_q[cnt_q][31:0] : 32'(t_q[cnt_q][29:0]);
  assign mul_p = mul_a * mul_a;
  assign acc_d = acc_q + 66'(mul_p);

  assign all_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  assign short_mag = (mag_q[0][SUM_BITS-1:32] == '0) && (mag_q[1][SUM_BITS-1:32] == '0)
                  && (mag_q[2][SUM_BITS-1:32] == '0);
  assign degen = all_zero || (short_mag && (acc_d < {2'b00, min_len_sq_i}));

  always_comb begin
    m_max = mag_q[0];
    if (mag_q[1] > m_max) m_max = mag_q[1];
    if (mag_q[2] > m_max) m_max = mag_q[2];
  end

  // Square root trial and division step
  assign root_try = root_res_q + root_bit_q;
  assign div_cand = 48'(root_res_q[31:0]) << step_q;

  always_comb begin
    quo_d = quo_q;
    if (div_n_q >= div_cand) quo_d[step_q] = 1'b1;
    comp_clamp = (quo_d > 17'd32767) ? {(NORM_W-1){1'b1}} : quo_d[NORM_W-2:0];
    comp_val = neg_q[cnt_q] ? -$signed({1'b0, comp_clamp}) : $signed({1'b0, comp_clamp});
  end

  assign can_load = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl_o.pop   = 1'b0;
    ctl_o.busy  = state_q == ST_CLEAR;
    pos_we      = 1'b0;
    pos_waddr   = IDX_W'(item_i.ia);
    pos_wdata   = {COORD_BITS'(item_i.cz), COORD_BITS'(item_i.cy), COORD_BITS'(item_i.cx)};
    pos_raddr   = ia_w;
    acc_we      = 1'b0;
    acc_waddr   = corner_w;
    acc_wdata   = {acc_new[2], acc_new[1], acc_new[0]};
    acc_raddr   = corner_w;
    case (state_q)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_cnt_q;
        acc_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IDX_W'(VERTICES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          ctl_o.pop = 1'b1;
          case (item_i.cls)
            CLS_LOAD:     pos_we  = 1'b1;
            CLS_TRI:      state_d = ST_PRD_A;
            CLS_READ:     state_d = ST_RD_SUM;
            CLS_READ_OOB: state_d = ST_OUT;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_PRD_A:  begin pos_raddr = ia_w; state_d = ST_PRD_B; end
      ST_PRD_B:  begin pos_raddr = ib_w; state_d = ST_PRD_C; end
      ST_PRD_C:  begin pos_raddr = ic_w; state_d = ST_PWAIT; end
      ST_PWAIT:  state_d = ST_MUL;
      ST_MUL:    state_d = ST_CROSS;
      ST_CROSS:  state_d = ST_ACC_RD;
      ST_ACC_RD: state_d = ST_ACC_WR;
      ST_ACC_WR: begin
        acc_we  = 1'b1;
        state_d = (cnt_q == 2'd2) ? ST_IDLE : ST_ACC_RD;
      end
      ST_RD_SUM:  begin acc_raddr = ia_w; state_d = ST_RD_WAIT; end
      ST_RD_WAIT: state_d = ST_SQ;
      ST_SQ: begin
        if (cnt_q == 2'd2) state_d = degen ? ST_OUT : ST_NORM;
      end
      ST_NORM: begin
        if (!(|m_q[SUM_BITS-1:30]) && m_q[29]) state_d = ST_TSQ;
      end
      ST_TSQ: begin
        if (cnt_q == 2'd2) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (root_bit_q == 64'd1) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == 5'd0) state_d = (cnt_q == 2'd2) ? ST_OUT : ST_DIV_INIT;
      end
      ST_OUT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (cur_q.cls == CLS_READ && cur_q.clr) begin
            acc_we    = 1'b1;
            acc_waddr = ia_w;
            acc_wdata = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cur_q <= item_i;
        for (int k = 0; k < 3; k++) res_q[k] <= '0;
        res_degen_q <= 1'b1;
      end
      ST_PRD_B: for (int k = 0; k < 3; k++) pa_q[k] <= pos_rd[k];
      ST_PRD_C: for (int k = 0; k < 3; k++) pb_q[k] <= pos_rd[k];
      ST_PWAIT: for (int k = 0; k < 3; k++) pc_q[k] <= pos_rd[k];
      ST_MUL: begin
        prod_q[0] <= PROD_W'(du[1]) * PROD_W'(dw[2]);
        prod_q[1] <= PROD_W'(du[2]) * PROD_W'(dw[1]);
        prod_q[2] <= PROD_W'(du[2]) * PROD_W'(dw[0]);
        prod_q[3] <= PROD_W'(du[0]) * PROD_W'(dw[2]);
        prod_q[4] <= PROD_W'(du[0]) * PROD_W'(dw[1]);
        prod_q[5] <= PROD_W'(du[1]) * PROD_W'(dw[0]);
      end
      ST_CROSS: begin
        cross_q[0] <= CROSS_W'(prod_q[0]) - CROSS_W'(prod_q[1]);
        cross_q[1] <= CROSS_W'(prod_q[2]) - CROSS_W'(prod_q[3]);
        cross_q[2] <= CROSS_W'(prod_q[4]) - CROSS_W'(prod_q[5]);
        cnt_q <= 2'd0;
      end
      ST_ACC_WR: cnt_q <= cnt_q + 2'd1;
      ST_RD_WAIT: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= sum_rd[k][SUM_BITS-1];
          mag_q[k] <= rd_mag[k];
          t_q[k]   <= rd_mag[k];
        end
        acc_q <= '0;
        cnt_q <= 2'd0;
      end
      ST_SQ: begin
        acc_q <= acc_d;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd0) m_q <= m_max;
        if (cnt_q == 2'd2) res_degen_q <= degen;
      end
      ST_NORM: begin
        if (|m_q[SUM_BITS-1:30]) begin
          m_q <= m_q >> 1;
          for (int k = 0; k < 3; k++) t_q[k] <= t_q[k] >> 1;
        end else if (!m_q[29]) begin
          m_q <= m_q << 1;
          for (int k = 0; k < 3; k++) t_q[k] <= t_q[k] << 1;
        end else begin
          acc_q <= '0;
          cnt_q <= 2'd0;
        end
      end
      ST_TSQ: begin
        acc_q <= acc_d;
        cnt_q <= cnt_q + 2'd1;
        root_n_q   <= acc_d[63:0];
        root_res_q <= '0;
        root_bit_q <= 64'd1 << 62;
      end
      ST_SQRT: begin
        if (root_n_q >= root_try) begin
          root_n_q   <= root_n_q - root_try;
          root_res_q <= (root_res_q >> 1) + root_bit_q;
        end else begin
          root_res_q <= root_res_q >> 1;
        end
        root_bit_q <= root_bit_q >> 2;
        cnt_q <= 2'd0;
      end
      ST_DIV_INIT: begin
        div_n_q <= 48'({t_q[cnt_q][29:0], 15'b0}) + 48'(root_res_q[31:1]);
        quo_q   <= '0;
        step_q  <= 5'd16;
      end
      ST_DIV: begin
        if (div_n_q >= div_cand) div_n_q <= div_n_q - div_cand;
        quo_q  <= quo_d;
        step_q <= step_q - 5'd1;
        if (step_q == 5'd0) begin
          res_q[cnt_q] <= comp_val;
          cnt_q <= cnt_q + 2'd1;
        end
      end
      ST_OUT: begin
        if (can_load) begin
          for (int k = 0; k < 3; k++) out_q[k] <= res_degen_q ? '0 : res_q[k];
          out_degen_q <= res_degen_q;
        end
      end
      default: cnt_q <= cnt_q;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = out_q[0];
  assign normal_y_o   = out_q[1];
  assign normal_z_o   = out_q[2];
  assign degenerate_o = out_degen_q;

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.pop |-> (state_q == ST_IDLE) && item_valid_i) else $error("pop outside idle");
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM) |-> m_q != '0) else $error("normalizing a zero vector");
  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> root_bit_q != '0) else $error("root step past end");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_q) else $error("result during clear pass");
`endif

endmodule

// ===== bench/area_weighted_vertex_normals_unit_test.sv =====
// Self-checking testbench of the area-weighted vertex normal accumulator.
module area_weighted_vertex_normals_unit_test;
  import awvn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NVERT    = 4096;
  localparam longint      SUM_MAX  = (64'sd1 <<< 47) - 1;
  localparam longint      SUM_MIN  = -SUM_MAX - 1;
  localparam int unsigned SETTLE   = 300;
  localparam int unsigned LIMIT    = 4000000;

  typedef struct {
    action_e            act;
    logic [11:0]        ia;
    logic [11:0]        ib;
    logic [11:0]        ic;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } mesh_op_t;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } unit_normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = '0;
  logic [11:0] index_a_i = '0, index_b_i = '0, index_c_i = '0;
  logic signed [15:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [63:0] cfg_data_i = '0;

  // Mirror of the block state
  logic signed [15:0] pos_x[NVERT], pos_y[NVERT], pos_z[NVERT];
  longint acc_x[NVERT], acc_y[NVERT], acc_z[NVERT];
  logic [63:0] min_len_sq = 64'd1;

  mesh_op_t     pending_ops[$];
  unit_normal_t normals_due[$];
  int           loaded_verts[$];
  bit           is_loaded[NVERT];

  mesh_op_t held_op;
  bit       holding = 0;
  int       tx_gap = 0;
  int       rx_wait = 0;
  bit       quiet = 0;
  logic     hold_rx = 1'b0;
  bit       pressure_go = 0;
  int       errors = 0;
  int       cycles = 0;

  area_weighted_vertex_normals_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
    .index_a_i, .index_b_i, .index_c_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o,
    .degenerate_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bv;
    res = '0;
    bv = 64'h4000_0000_0000_0000;
    while (bv > n) bv = bv >> 2;
    while (bv != 0) begin
      if (n >= res + bv) begin
        n = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  function automatic logic signed [15:0] q15_comp(longint s, logic [63:0] t, logic [63:0] r);
    logic [63:0] q;
    q = (t * 64'd32768 + (r >> 1)) / r;
    if (q > 64'd32767) q = 64'd32767;
    return s < 0 ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  // Unit normal of one accumulated vector, degenerate under the threshold
  function automatic unit_normal_t normalize(longint sx, longint sy, longint sz);
    unit_normal_t res;
    logic [63:0] ax, ay, az, m, tx, ty, tz, r;
    logic [127:0] sq;
    int p;
    res = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
    ax = sx < 0 ? 64'(-sx) : 64'(sx);
    ay = sy < 0 ? 64'(-sy) : 64'(sy);
    az = sz < 0 ? 64'(-sz) : 64'(sz);
    sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
    if (sq == 0 || (sq[127:64] == 0 && sq[63:0] < min_len_sq)) return res;
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    tx = p > 29 ? ax >> (p - 29) : ax << (29 - p);
    ty = p > 29 ? ay >> (p - 29) : ay << (29 - p);
    tz = p > 29 ? az >> (p - 29) : az << (29 - p);
    r = int_sqrt(tx * tx + ty * ty + tz * tz);
    res.nx = q15_comp(sx, tx, r);
    res.ny = q15_comp(sy, ty, r);
    res.nz = q15_comp(sz, tz, r);
    res.degen = 1'b0;
    return res;
  endfunction

  // Advance the mirrored state by one accepted item
  task automatic apply_op(mesh_op_t op);
    longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
    int corner[3];
    case (op.act)
      ACT_LOAD: begin
        pos_x[op.ia] = op.cx;
        pos_y[op.ia] = op.cy;
        pos_z[op.ia] = op.cz;
      end
      ACT_TRI: begin
        ux = longint'(pos_x[op.ib]) - longint'(pos_x[op.ia]);
        uy = longint'(pos_y[op.ib]) - longint'(pos_y[op.ia]);
        uz = longint'(pos_z[op.ib]) - longint'(pos_z[op.ia]);
        wx = longint'(pos_x[op.ic]) - longint'(pos_x[op.ia]);
        wy = longint'(pos_y[op.ic]) - longint'(pos_y[op.ia]);
        wz = longint'(pos_z[op.ic]) - longint'(pos_z[op.ia]);
        nx = uy * wz - uz * wy;
        ny = uz * wx - ux * wz;
        nz = ux * wy - uy * wx;
        corner = '{int'(op.ia), int'(op.ib), int'(op.ic)};
        foreach (corner[k]) begin
          acc_x[corner[k]] = clamp_add(acc_x[corner[k]], nx);
          acc_y[corner[k]] = clamp_add(acc_y[corner[k]], ny);
          acc_z[corner[k]] = clamp_add(acc_z[corner[k]], nz);
        end
      end
      default: begin
        normals_due.push_back(normalize(acc_x[op.ia], acc_y[op.ia], acc_z[op.ia]));
        if (op.act == ACT_READ_CLR) begin
          acc_x[op.ia] = 0;
          acc_y[op.ia] = 0;
          acc_z[op.ia] = 0;
        end
      end
    endcase
  endtask

  task automatic queue_op(action_e act, int a, int b, int c, int x, int y, int z);
    mesh_op_t op;
    op = '{act: act, ia: a[11:0], ib: b[11:0], ic: c[11:0],
           cx: x[15:0], cy: y[15:0], cz: z[15:0]};
    if (act == ACT_LOAD && !is_loaded[a]) begin
      is_loaded[a] = 1;
      loaded_verts.push_back(a);
    end
    pending_ops.push_back(op);
  endtask

  function automatic int any_coord();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 40) - 20;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_loaded();
    return loaded_verts[$urandom_range(0, loaded_verts.size() - 1)];
  endfunction

  // Random mix of triangles over loaded vertices, loads and reads; triangles lead
  task automatic queue_random(int n);
    int a, sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      a = $urandom_range(0, 3) == 0 ? $urandom_range(0, NVERT - 1) : $urandom_range(0, 31);
      if (sel < 25)
        queue_op(ACT_LOAD, a, $urandom_range(0, NVERT - 1), $urandom_range(0, NVERT - 1),
                 any_coord(), any_coord(), any_coord());
      else if (sel < 65)
        queue_op(ACT_TRI, pick_loaded(), pick_loaded(), pick_loaded(), any_coord(),
                 any_coord(), any_coord());
      else
        queue_op(sel < 83 ? ACT_READ : ACT_READ_CLR,
                 $urandom_range(0, 1) ? pick_loaded() : a,
                 $urandom_range(0, NVERT - 1), $urandom_range(0, NVERT - 1),
                 any_coord(), any_coord(), any_coord());
    end
  endtask

  // Wait for all results plus the tail of a result-free item
  task automatic drain();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || holding || normals_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_len_sq = v;
  endtask

  // Driver: hands items from the pending queue to the input channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_op(held_op);
        holding = 0;
        tx_gap = quiet || $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (!holding) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_ops.size() != 0) begin
          held_op = pending_ops.pop_front();
          holding = 1;
        end
      end
      in_valid_i <= holding;
      action_i   <= held_op.act;
      index_a_i  <= held_op.ia;
      index_b_i  <= held_op.ib;
      index_c_i  <= held_op.ic;
      coord_x_i  <= held_op.cx;
      coord_y_i  <= held_op.cy;
      coord_z_i  <= held_op.cz;
    end
  end

  // Monitor: takes result items and checks them against the oldest normal due
  always @(posedge clk_i or negedge rst_ni) begin
    unit_normal_t exp_n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (normals_due.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_n = normals_due.pop_front();
          if (normal_x_o !== exp_n.nx) begin
            $error("normal_x expected %0d actual %0d", exp_n.nx, normal_x_o);
            errors++;
          end
          if (normal_y_o !== exp_n.ny) begin
            $error("normal_y expected %0d actual %0d", exp_n.ny, normal_y_o);
            errors++;
          end
          if (normal_z_o !== exp_n.nz) begin
            $error("normal_z expected %0d actual %0d", exp_n.nz, normal_z_o);
            errors++;
          end
          if (degenerate_o !== exp_n.degen) begin
            $error("degenerate expected %0d actual %0d", exp_n.degen, degenerate_o);
            errors++;
          end
        end
        rx_wait = quiet || $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= hold_rx || rx_wait > 0;
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (pressure_go);
    repeat (40) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("area_weighted_vertex_normals_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (acc_x[i]) begin
      acc_x[i] = 0;
      acc_y[i] = 0;
      acc_z[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme coordinates, every action, zero and untouched reads
    queue_op(ACT_LOAD, 0, 0, 0, -32768, -32768, -32768);
    queue_op(ACT_LOAD, 1, 4095, 4095, 32767, 0, -32768);
    queue_op(ACT_LOAD, 2, 0, 0, 0, 32767, 32767);
    queue_op(ACT_LOAD, 4095, 0, 0, 32767, 32767, 32767);
    queue_op(ACT_LOAD, 2048, 0, 0, 1, -1, 0);
    queue_op(ACT_TRI, 0, 1, 2, 0, 0, 0);
    queue_op(ACT_TRI, 4095, 2048, 0, 0, 0, 0);
    queue_op(ACT_TRI, 0, 0, 1, 0, 0, 0);
    queue_op(ACT_TRI, 2, 1, 0, 0, 0, 0);
    queue_op(ACT_READ, 0, 0, 0, 0, 0, 0);
    queue_op(ACT_READ, 1, 0, 0, 0, 0, 0);
    queue_op(ACT_READ, 4095, 0, 0, 0, 0, 0);
    queue_op(ACT_READ_CLR, 2, 0, 0, 0, 0, 0);
    queue_op(ACT_READ, 2, 0, 0, 0, 0, 0);
    queue_op(ACT_READ, 100, 0, 0, 0, 0, 0);
    queue_op(ACT_READ_CLR, 2048, 4095, 4095, -1, -1, -1);
    queue_op(ACT_READ, 2048, 0, 0, 0, 0, 0);
    drain();

    write_threshold(64'd0);
    queue_random(350);
    drain();

    write_threshold(64'hFFFF_FFFF_FFFF_FFFF);
    queue_random(150);
    drain();

    write_threshold(64'd1 << 40);
    pressure_go = 1;
    queue_random(300);
    drain();

    // Large sums: one big triangle repeated, x high and y low
    write_threshold(64'd1);
    quiet = 1;
    queue_op(ACT_LOAD, 10, 0, 0, -32768, -32768, 32767);
    queue_op(ACT_LOAD, 11, 0, 0, 32767, 32767, -32768);
    queue_op(ACT_LOAD, 12, 0, 0, 32767, 32767, 32767);
    queue_op(ACT_READ_CLR, 10, 0, 0, 0, 0, 0);
    queue_op(ACT_READ_CLR, 11, 0, 0, 0, 0, 0);
    repeat (20) queue_op(ACT_TRI, 10, 11, 12, 0, 0, 0);
    queue_op(ACT_READ, 10, 0, 0, 0, 0, 0);
    queue_op(ACT_READ_CLR, 11, 0, 0, 0, 0, 0);
    drain();
    quiet = 0;

    write_threshold({$urandom(), $urandom()} >> $urandom_range(0, 63));
    queue_random(300);
    drain();

    if (errors == 0) begin
      $display("area_weighted_vertex_normals_unit_test OK");
    end else begin
      $display("area_weighted_vertex_normals_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/awvn_pkg.sv
hdl/awvn_ram.sv
hdl/awvn_front.sv
hdl/awvn_back.sv
hdl/area_weighted_vertex_normals_unit.sv
bench/area_weighted_vertex_normals_unit_test.sv
